// ===== design/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// shared constants for the breakpoint-table interpolator
// ----------------------------------------------------------------------------
package tli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int VAL_W       = 32;
   localparam int CSR_IDX_W   = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BELOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ABOVE  = 2'd2;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // range codes
   localparam logic [1:0] RANGE_IN    = 2'd0;
   localparam logic [1:0] RANGE_BELOW = 2'd1;
   localparam logic [1:0] RANGE_ABOVE = 2'd2;

endpackage

// ===== design/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator
// piecewise linear interpolation over a table of up to 256 breakpoints
// ----------------------------------------------------------------------------
// Usage:
//   req channel: a load item (req_mode 0) writes x/y at req_entry_index and
//   gives no result. A query item (req_mode 1) gives one rsp item.
//   csr port: points_in_use, below_value, above_value; write only while idle.
//   A query in range runs a binary search (up to 8 steps for 256 points): one
//   table read per step through the single read port of the x/y memories,
//   then a 32 by 32 multiply and a one-bit-per-cycle divider. Queries are
//   handled one at a time; req_stall is high while a query is busy, and a
//   load is taken without a stall.
//   The result sits in an output register; the next item is accepted while
//   it waits, and a new result waits in its last state until that register
//   is free, so rsp_stall only holds back the block.
//   Reset clears the controller and the registers to points_in_use 2,
//   below/above 0; the table memories are not cleared, so every entry that
//   a query can touch must be loaded first.
// ----------------------------------------------------------------------------
module table_linear_interpolator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [tli_pkg::IDX_W-1:0]     req_entry_index,
   input  logic signed [tli_pkg::VAL_W-1:0] req_entry_x,
   input  logic signed [tli_pkg::VAL_W-1:0] req_entry_y,
   input  logic signed [tli_pkg::VAL_W-1:0] req_query_x,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [tli_pkg::VAL_W-1:0] rsp_y_result,
   output logic [1:0]                    rsp_range_code,
   input  logic                          csr_we,
   input  logic [tli_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tli_pkg::VAL_W-1:0]     csr_wdata
);
   import tli_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_CHK_HI  = 9'b000000010,
      S_CHK_LO  = 9'b000000100,
      S_SRCH    = 9'b000001000,
      S_FETCH_L = 9'b000010000,
      S_FETCH_R = 9'b000100000,
      S_MUL     = 9'b001000000,
      S_DIV     = 9'b010000000,
      S_OUT     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [CNT_W-1:0]        points_ff;
   logic signed [VAL_W-1:0] below_ff, above_ff;

   // table memories
   logic signed [VAL_W-1:0] x_mem [TABLE_DEPTH];
   logic signed [VAL_W-1:0] y_mem [TABLE_DEPTH];
   logic signed [VAL_W-1:0] x_rd_ff, y_rd_ff;
   logic [IDX_W-1:0]        rd_addr;

   // query working registers
   logic signed [VAL_W-1:0] q_ff, q_in;
   logic [IDX_W-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic signed [VAL_W-1:0] xl_ff, xl_in, yl_ff, yl_in;
   logic [2*VAL_W-1:0]      prod_ff, prod_in;
   logic [VAL_W-1:0]        dx_ff, dx_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] res_ff, res_in;
   logic [1:0]              code_ff, code_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_y_ff, rsp_y_in;
   logic [1:0]              rsp_code_ff, rsp_code_in;

   logic                    req_take, out_free;
   logic [IDX_W-1:0]        last_idx, mid_new;
   logic [IDX_W:0]          mid_sum;
   logic signed [VAL_W:0]   dq_w, dx_w, dy_w;
   logic [VAL_W-1:0]        mag;
   logic                    div_start;
   logic                    div_done;
   logic [VAL_W-1:0]        quo;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // entry count clamped to 2..TABLE_DEPTH, as a last index
   always_comb begin
      if (points_ff < CNT_W'(2))
         last_idx = IDX_W'(1);
      else if (points_ff > CNT_W'(TABLE_DEPTH))
         last_idx = IDX_W'(TABLE_DEPTH - 1);
      else
         last_idx = IDX_W'(points_ff - 1'b1);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= CNT_W'(2);
         below_ff  <= '0;
         above_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POINTS: points_ff <= csr_wdata[CNT_W-1:0];
            CSR_BELOW:  below_ff  <= csr_wdata;
            CSR_ABOVE:  above_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table write on load, registered read every cycle
   always_ff @(posedge clock) begin
      if (req_take && req_mode == MODE_LOAD) begin
         x_mem[req_entry_index] <= req_entry_x;
         y_mem[req_entry_index] <= req_entry_y;
      end
      x_rd_ff <= x_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   // search step and interpolation arithmetic
   always_comb begin
      dq_w = {q_ff[VAL_W-1], q_ff} - {xl_ff[VAL_W-1], xl_ff};
      dx_w = {x_rd_ff[VAL_W-1], x_rd_ff} - {xl_ff[VAL_W-1], xl_ff};
      dy_w = {y_rd_ff[VAL_W-1], y_rd_ff} - {yl_ff[VAL_W-1], yl_ff};
      mag  = dy_w[VAL_W] ? VAL_W'(-dy_w) : dy_w[VAL_W-1:0];
      if (state_ff == S_SRCH && q_ff > x_rd_ff) begin
         lo_in = mid_new;
         hi_in = hi_ff;
      end else if (state_ff == S_SRCH) begin
         lo_in = lo_ff;
         hi_in = mid_new;
      end else begin
         lo_in = lo_ff;
         hi_in = hi_ff;
      end
      mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
   end

   // mid of the bracket currently being read
   always_comb begin
      mid_new = IDX_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   end

   // controller
   always_comb begin
      state_in     = state_ff;
      rd_addr      = last_idx;
      q_in         = q_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      prod_in      = prod_ff;
      dx_in        = dx_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      code_in      = code_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            q_in = req_query_x;
            if (req_take && req_mode == MODE_QUERY)
               state_in = S_CHK_HI;
         end
         S_CHK_HI: begin
            rd_addr = '0;
            if (q_ff > x_rd_ff) begin
               res_in   = above_ff;
               code_in  = RANGE_ABOVE;
               state_in = S_OUT;
            end else begin
               state_in = S_CHK_LO;
            end
         end
         S_CHK_LO: begin
            rd_addr = mid_new;
            if (q_ff < x_rd_ff) begin
               res_in   = below_ff;
               code_in  = RANGE_BELOW;
               state_in = S_OUT;
            end else if (hi_ff - lo_ff > IDX_W'(1)) begin
               state_in = S_SRCH;
            end else begin
               rd_addr  = lo_ff;
               state_in = S_FETCH_L;
            end
         end
         S_SRCH: begin
            if (hi_in - lo_in > IDX_W'(1)) begin
               rd_addr = mid_sum[IDX_W:1];
            end else begin
               rd_addr  = lo_in;
               state_in = S_FETCH_L;
            end
         end
         S_FETCH_L: begin
            rd_addr  = hi_ff;
            xl_in    = x_rd_ff;
            yl_in    = y_rd_ff;
            state_in = S_FETCH_R;
         end
         S_FETCH_R: begin
            code_in = RANGE_IN;
            neg_in  = dy_w[VAL_W];
            dx_in   = dx_w[VAL_W-1:0];
            prod_in = (2*VAL_W)'(dq_w[VAL_W-1:0]) * (2*VAL_W)'(mag);
            if (x_rd_ff <= xl_ff) begin
               res_in   = yl_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = neg_ff ? yl_ff - $signed(quo) : yl_ff + $signed(quo);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_y_in     = rsp_y_ff;
      rsp_code_in  = rsp_code_ff;
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_y_in     = res_ff;
         rsp_code_in  = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_IDLE) begin
         lo_ff <= '0;
         hi_ff <= last_idx;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      q_ff        <= q_in;
      xl_ff       <= xl_in;
      yl_ff       <= yl_in;
      prod_ff     <= prod_in;
      dx_ff       <= dx_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      code_ff     <= code_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_code_ff <= rsp_code_in;
   end

   // divider: product by bracket width
   tli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_y_result   = rsp_y_ff;
   assign rsp_range_code = rsp_code_ff;

`ifndef ASSERT_OFF
   // the search only runs on a bracket wider than one step
   a_srch_bracket: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH |-> (hi_ff - lo_ff > IDX_W'(1)))
      else $error("search on a degenerate bracket");

   // divider finishes only while the controller waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside divide state");

   // an item accepted in idle is a query only if the controller leaves idle
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_mode == MODE_QUERY) |=> state_ff == S_CHK_HI)
      else $error("query item did not start a lookup");

   // a result is only loaded when the output register is free
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(rsp_y_ff) && $stable(rsp_code_ff)))
      else $error("pending result overwritten");
`endif

endmodule

// ===== design/tli_div.sv =====
// ----------------------------------------------------------------------------
// tli_div
// restoring divider, 64 by 32 bits unsigned, one quotient bit per cycle;
// the caller guarantees the quotient fits in 32 bits
// ----------------------------------------------------------------------------
module tli_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2*tli_pkg::VAL_W-1:0] dividend,
   input  logic [tli_pkg::VAL_W-1:0] divisor,
   output logic                      done,
   output logic [tli_pkg::VAL_W-1:0] quotient
);
   import tli_pkg::*;

   localparam int STEP_W = $clog2(VAL_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  quo_ff, quo_in;
   logic [VAL_W-1:0]  dvs_ff, dvs_in;
   logic [VAL_W:0]    trial;

   // one trial subtraction per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[VAL_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[2*VAL_W-1:VAL_W];
         quo_in  = dividend[VAL_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = VAL_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_in = trial[VAL_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
